// File: sv/tle_pkg.sv
// Shared types and character, result and decoder codes for the terminal line editor.
package tle_pkg;

   // Result kinds carried on the response channel.
   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;
   localparam logic [1:0] KIND_FKEY  = 2'd3;

   // Request opcodes.
   localparam logic OP_RX   = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Control characters and escape sequence characters.
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_O   = 8'h4F;
   localparam logic [7:0] CH_P   = 8'h50;
   localparam logic [7:0] CH_Q   = 8'h51;
   localparam logic [7:0] CH_R   = 8'h52;
   localparam logic [7:0] CH_S   = 8'h53;

   // Escape decoder steps.
   localparam logic [1:0] ESC_IDLE = 2'd0;
   localparam logic [1:0] ESC_GOT  = 2'd1;
   localparam logic [1:0] ESC_SS3  = 2'd2;

   // Verdict of the escape decoder on one received byte.
   typedef struct packed {
      logic       pending;  // byte was consumed by an unfinished sequence
      logic       fkey;     // byte completed a function key sequence
      logic [1:0] key;      // function key number minus one
   } esc_res_type;

endpackage

// File: sv/tle_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
module tle_ram #(
   parameter int DEPTH = 80,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; data shows in the cycle after the address and holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/tle_esc_dec.sv
// Escape sequence decoder that turns ESC O P/Q/R/S into function keys F1 to F4.
module tle_esc_dec (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          rx_byte,
   output tle_pkg::esc_res_type res
);
   import tle_pkg::*;

   logic [1:0] step_ff;
   logic [1:0] step_in;

   // Verdict and next step for the byte on rx_byte.
   always_comb begin
      res     = '0;
      step_in = ESC_IDLE;
      case (step_ff)
         ESC_IDLE: begin
            if (rx_byte == CH_ESC) begin
               res.pending = 1'b1;
               step_in     = ESC_GOT;
            end
         end
         ESC_GOT: begin
            if (rx_byte == CH_O) begin
               res.pending = 1'b1;
               step_in     = ESC_SS3;
            end
         end
         ESC_SS3: begin
            // P, Q, R and S differ only in their two low bits, which give the key.
            if (rx_byte == CH_P || rx_byte == CH_Q || rx_byte == CH_R || rx_byte == CH_S) begin
               res.fkey = 1'b1;
               res.key  = rx_byte[1:0];
            end
         end
         default: begin
            step_in = ESC_IDLE;
         end
      endcase
   end

   // The step only moves on received bytes.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ESC_IDLE;
      end else if (step_en) begin
         step_ff <= step_in;
      end
   end

endmodule

// File: sv/tty_line_editor_with_input_fifo_core.sv
// Top level of the canonical-mode terminal line editor with its input FIFO.
//
// Each request beat is either a received keyboard byte or a read of one character
// from the input FIFO. The edit line and the FIFO each live in a synchronous RAM
// with one read and one write port, and one request is worked on at a time. On
// Enter the line is moved into the FIFO through the single edit RAM read port at
// one character per cycle. Response stalls can hold a request. A new request is
// taken as soon as the last response beat of the previous one is loaded into the
// output register, so a waiting response does not block input. The user must write
// echo control through the csr port only while no request is in flight; the block
// itself does not enforce this. csr_ready is always high.
module tty_line_editor_with_input_fifo_core #(
   parameter int EDIT_LEN   = 80,
   parameter int FIFO_DEPTH = 80
) (
   input  logic       clock,
   input  logic       reset,
   // Request channel.
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_rx_byte,
   // Response channel.
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_fn_key,
   output logic       rsp_last,
   // Configuration write channel.
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_echo_enable
);
   import tle_pkg::*;

   localparam int EW    = $clog2(EDIT_LEN);
   localparam int FILLW = $clog2(EDIT_LEN + 1);
   localparam int FW    = $clog2(FIFO_DEPTH);
   localparam int LW    = $clog2(FIFO_DEPTH + 1);

   localparam logic [FILLW-1:0] FILL_MAX = FILLW'(EDIT_LEN);
   localparam logic [FW-1:0]    POS_LAST = FW'(FIFO_DEPTH - 1);
   localparam logic [LW-1:0]    LVL_MAX  = LW'(FIFO_DEPTH);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_KEY     = 3'd1;
   localparam logic [2:0] ST_RD      = 3'd2;
   localparam logic [2:0] ST_RD_EMIT = 3'd3;
   localparam logic [2:0] ST_COPY    = 3'd4;
   localparam logic [2:0] ST_PUSH_NL = 3'd5;
   localparam logic [2:0] ST_ECHO_CR = 3'd6;
   localparam logic [2:0] ST_ECHO_LF = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic             op_ff, op_in;
   logic [7:0]       byte_ff, byte_in;
   esc_res_type      esc_ff, esc_in;
   logic [FILLW-1:0] fill_ff, fill_in;
   logic [FILLW-1:0] cnt_ff, cnt_in;
   logic             rvld_ff, rvld_in;
   logic [FW-1:0]    wr_pos_ff, wr_pos_in;
   logic [FW-1:0]    rd_pos_ff, rd_pos_in;
   logic [LW-1:0]    level_ff, level_in;
   logic             echo_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]       rsp_key_ff, rsp_key_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_accept;
   logic             out_free;
   esc_res_type      esc_res;

   logic             edit_we;
   logic             edit_re;
   logic [7:0]       edit_rdata;
   logic             fifo_we;
   logic [7:0]       fifo_wdata;
   logic             fifo_re;
   logic [7:0]       fifo_rdata;

   logic             emit;
   logic [1:0]       emit_kind;
   logic [7:0]       emit_data;
   logic [1:0]       emit_key;
   logic             emit_last;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // Edit line storage, indexed by fill level on write and copy count on read.
   tle_ram #(
      .DEPTH(EDIT_LEN),
      .WIDTH(8)
   ) u_edit_ram (
      .clock  (clock),
      .wr_en  (edit_we),
      .wr_addr(fill_ff[EW-1:0]),
      .wr_data(byte_ff),
      .rd_en  (edit_re),
      .rd_addr(cnt_ff[EW-1:0]),
      .rd_data(edit_rdata)
   );

   // Input FIFO storage; pushes and pops are never in the same cycle.
   tle_ram #(
      .DEPTH(FIFO_DEPTH),
      .WIDTH(8)
   ) u_fifo_ram (
      .clock  (clock),
      .wr_en  (fifo_we),
      .wr_addr(wr_pos_ff),
      .wr_data(fifo_wdata),
      .rd_en  (fifo_re),
      .rd_addr(rd_pos_ff),
      .rd_data(fifo_rdata)
   );

   // Escape decoder sees the request byte and steps only on received bytes.
   tle_esc_dec u_esc_dec (
      .clock  (clock),
      .reset  (reset),
      .step_en(req_accept && (req_opcode == OP_RX)),
      .rx_byte(req_rx_byte),
      .res    (esc_res)
   );

   // Request sequencer. Edit RAM and FIFO RAM accesses are ordered by state, so a
   // read never meets a write to the same entry and no forwarding is needed.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      byte_in    = byte_ff;
      esc_in     = esc_ff;
      fill_in    = fill_ff;
      cnt_in     = cnt_ff;
      rvld_in    = rvld_ff;
      wr_pos_in  = wr_pos_ff;
      rd_pos_in  = rd_pos_ff;
      level_in   = level_ff;
      edit_we    = 1'b0;
      edit_re    = 1'b0;
      fifo_we    = 1'b0;
      fifo_wdata = CH_LF;
      fifo_re    = 1'b0;
      emit       = 1'b0;
      emit_kind  = KIND_ECHO;
      emit_data  = CH_NUL;
      emit_key   = 2'd0;
      emit_last  = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in    = req_opcode;
               byte_in  = req_rx_byte;
               esc_in   = esc_res;
               state_in = (req_opcode == OP_READ) ? ST_RD : ST_KEY;
            end
         end
         ST_RD: begin
            if (out_free) begin
               if (level_ff == '0) begin
                  emit      = 1'b1;
                  emit_kind = KIND_EMPTY;
                  state_in  = ST_IDLE;
               end else begin
                  fifo_re   = 1'b1;
                  rd_pos_in = (rd_pos_ff == POS_LAST) ? '0 : rd_pos_ff + 1'b1;
                  level_in  = level_ff - 1'b1;
                  state_in  = ST_RD_EMIT;
               end
            end
         end
         ST_RD_EMIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = KIND_DATA;
               emit_data = fifo_rdata;
               state_in  = ST_IDLE;
            end
         end
         ST_KEY: begin
            if (esc_ff.pending) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               if (esc_ff.fkey) begin
                  emit      = 1'b1;
                  emit_kind = KIND_FKEY;
                  emit_key  = esc_ff.key;
                  state_in  = ST_IDLE;
               end else if (byte_ff == CH_CR || byte_ff == CH_LF) begin
                  cnt_in   = '0;
                  rvld_in  = 1'b0;
                  state_in = ST_COPY;
               end else if (byte_ff == CH_BS) begin
                  if (fill_ff != '0) begin
                     fill_in   = fill_ff - 1'b1;
                     emit      = echo_ff;
                     emit_data = CH_BS;
                  end
                  state_in = ST_IDLE;
               end else begin
                  // A full line drops the byte but still echoes it.
                  if (fill_ff < FILL_MAX) begin
                     edit_we = 1'b1;
                     fill_in = fill_ff + 1'b1;
                  end
                  emit      = echo_ff && (byte_ff != CH_NUL);
                  emit_data = byte_ff;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_COPY: begin
            // One edit RAM read issued per cycle; the previous read's byte is pushed.
            if (rvld_ff && (edit_rdata == CH_NUL)) begin
               rvld_in  = 1'b0;
               state_in = ST_PUSH_NL;
            end else begin
               if (rvld_ff) begin
                  fifo_we    = 1'b1;
                  fifo_wdata = edit_rdata;
               end
               if (cnt_ff < fill_ff) begin
                  edit_re = 1'b1;
                  cnt_in  = cnt_ff + 1'b1;
                  rvld_in = 1'b1;
               end else begin
                  rvld_in = 1'b0;
                  if (!rvld_ff) begin
                     state_in = ST_PUSH_NL;
                  end
               end
            end
         end
         ST_PUSH_NL: begin
            fifo_we    = 1'b1;
            fifo_wdata = CH_LF;
            fill_in    = '0;
            state_in   = echo_ff ? ST_ECHO_CR : ST_IDLE;
         end
         ST_ECHO_CR: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = CH_CR;
               emit_last = 1'b0;
               state_in  = ST_ECHO_LF;
            end
         end
         ST_ECHO_LF: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = CH_LF;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A push into a full FIFO drops the oldest entry.
      if (fifo_we) begin
         wr_pos_in = (wr_pos_ff == POS_LAST) ? '0 : wr_pos_ff + 1'b1;
         if (level_ff < LVL_MAX) begin
            level_in = level_ff + 1'b1;
         end else begin
            rd_pos_in = (rd_pos_ff == POS_LAST) ? '0 : rd_pos_ff + 1'b1;
         end
      end
   end

   // Output register loads a new beat or empties when its beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_data_in  = emit_data;
         rsp_key_in   = emit_key;
         rsp_last_in  = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rvld_ff      <= 1'b0;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         echo_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rvld_ff      <= rvld_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            echo_ff <= csr_echo_enable;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      byte_ff     <= byte_in;
      esc_ff      <= esc_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_data_byte   = rsp_data_ff;
   assign rsp_fn_key      = rsp_key_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   // The FIFO level never exceeds its depth.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_MAX)
      else $error("fifo level above depth");

   // The edit line never holds more than its length.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("edit fill above line length");

   // A FIFO pop only happens on a read request with data queued.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      fifo_re |-> (level_ff != '0) && (op_ff == OP_READ))
      else $error("fifo popped while empty or outside a read");

   // Memory writes never happen while a new request may be accepted.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !fifo_we && !edit_we)
      else $error("memory write while idle");
`endif

endmodule
